/* hw/rtl/arm_shifter_operand_core_assert.svh */
// assertion macros shared by the checker
// every macro samples on clk and is off while arst_n is low
`ifndef ARM_SHIFTER_OPERAND_CORE_ASSERT_SVH
`define ARM_SHIFTER_OPERAND_CORE_ASSERT_SVH

// same-cycle implication
`define ASO_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASO_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* hw/rtl/aso_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aso_pkg
// Types and constants shared by the shifter operand pipeline.
// ----------------------------------------------------------------------------
package aso_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned AmtW  = 8;
	localparam int unsigned ShW   = 5;
	localparam int unsigned KindW = 2;
	localparam int unsigned WideW = 2 * WordW + 1;

	typedef enum logic [KindW-1:0] {
		KIND_LSL = 2'd0,
		KIND_LSR = 2'd1,
		KIND_ASR = 2'd2,
		KIND_ROR = 2'd3
	} kind_t;

	// what the last stage builds for one request
	typedef enum logic [2:0] {
		OP_SHIFT,
		OP_PASS_CIN,
		OP_PASS_B31,
		OP_ZERO_B0,
		OP_ZERO_B31,
		OP_ZERO,
		OP_FILL,
		OP_RRX
	} op_t;

	typedef struct packed {
		logic valid;
		logic load;
	} stage_ctl_t;

	typedef struct packed {
		logic [WordW-1:0] rm;
		logic             cin;
		kind_t            kind;
		op_t              op;
		logic [ShW-1:0]   amt;
	} dec_t;

	typedef struct packed {
		logic [WideW-1:0] word;
		logic [1:0]       amt_fine;
		logic [WordW-1:0] rm;
		logic             cin;
		logic             lsl;
		op_t              op;
	} crs_t;

endpackage
`default_nettype wire

/* hw/rtl/aso_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aso_req_if
// Request channel: operand, shift control and carry flag.
// ----------------------------------------------------------------------------
interface aso_req_if;
	import aso_pkg::*;

	logic             valid;
	logic             ready;
	logic [WordW-1:0] rm_value;
	logic [AmtW-1:0]  rs_amount;
	logic             by_register;
	logic [KindW-1:0] shift_kind;
	logic [ShW-1:0]   shift_immediate;
	logic             carry_in;

	modport source (
		output valid, rm_value, rs_amount, by_register, shift_kind, shift_immediate,
			carry_in,
		input  ready
	);
	modport sink (
		input  valid, rm_value, rs_amount, by_register, shift_kind, shift_immediate,
			carry_in,
		output ready
	);
endinterface
`default_nettype wire

/* hw/rtl/aso_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aso_rsp_if
// Response channel: shifted operand and shifter carry.
// ----------------------------------------------------------------------------
interface aso_rsp_if;
	import aso_pkg::*;

	logic             valid;
	logic             ready;
	logic [WordW-1:0] operand_value;
	logic             carry_out;

	modport source (output valid, operand_value, carry_out, input ready);
	modport sink (input valid, operand_value, carry_out, output ready);
endinterface
`default_nettype wire

/* hw/rtl/arm_shifter_operand_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arm_shifter_operand_core
// ARM data-processing second operand with shifter carry-out.
// ----------------------------------------------------------------------------
// Takes one request per cycle while the response side is not stalled and
// returns its operand and carry: stage 1 decodes the amount and the special
// cases, stage 2 shifts the word by multiples of four, stage 3 finishes the
// shift, picks the result and holds it in the output register.
// Each stage moves on when the stage after it is empty or moving, so a stall
// on the response side holds every request in place and ready follows it in
// the same cycle.
module arm_shifter_operand_core (
	input  wire       clk,
	input  wire       arst_n,
	aso_req_if.sink   req,
	aso_rsp_if.source rsp
);
	import aso_pkg::*;

	logic       valid_s1;
	logic       valid_s2;
	logic       valid_s3;
	logic       adv1;
	logic       adv2;
	logic       adv3;
	stage_ctl_t ctl1;
	stage_ctl_t ctl2;
	stage_ctl_t ctl3;
	dec_t       dec_s1;
	crs_t       crs_s2;

	assign adv3 = !valid_s3 || rsp.ready;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;

	assign ctl1 = '{valid: req.valid, load: adv1};
	assign ctl2 = '{valid: valid_s1, load: adv2};
	assign ctl3 = '{valid: valid_s2, load: adv3};

	assign req.ready = adv1;
	assign rsp.valid = valid_s3;

	aso_decode_stage u_decode (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl1),
		.rm_value        (req.rm_value),
		.rs_amount       (req.rs_amount),
		.by_register     (req.by_register),
		.shift_kind      (req.shift_kind),
		.shift_immediate (req.shift_immediate),
		.carry_in        (req.carry_in),
		.valid_s1        (valid_s1),
		.dec_s1          (dec_s1)
	);

	aso_coarse_stage u_coarse (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl2),
		.dec_s1   (dec_s1),
		.valid_s2 (valid_s2),
		.crs_s2   (crs_s2)
	);

	aso_fine_stage u_fine (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl3),
		.crs_s2   (crs_s2),
		.valid_s3 (valid_s3),
		.value_s3 (rsp.operand_value),
		.carry_s3 (rsp.carry_out)
	);
endmodule
`default_nettype wire

/* hw/rtl/aso_decode_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aso_decode_stage
// Stage 1: resolves the amount source and the zero / out-of-range cases.
// ----------------------------------------------------------------------------
module aso_decode_stage (
	input  wire                         clk,
	input  wire                         arst_n,
	input  aso_pkg::stage_ctl_t         ctl,
	input  wire [aso_pkg::WordW-1:0]    rm_value,
	input  wire [aso_pkg::AmtW-1:0]     rs_amount,
	input  wire                         by_register,
	input  wire [aso_pkg::KindW-1:0]    shift_kind,
	input  wire [aso_pkg::ShW-1:0]      shift_immediate,
	input  wire                         carry_in,
	output logic                        valid_s1,
	output aso_pkg::dec_t               dec_s1
);
	import aso_pkg::*;

	dec_t           dec;
	kind_t          kind;
	logic [ShW-1:0] amt_raw;
	logic           rs_zero;
	logic           rs_lt32;
	logic           rs_eq32;

	assign kind    = kind_t'(shift_kind);
	assign amt_raw = by_register ? rs_amount[ShW-1:0] : shift_immediate;
	assign rs_zero = (rs_amount == '0);
	assign rs_lt32 = (rs_amount[AmtW-1:ShW] == '0);
	assign rs_eq32 = (rs_amount == AmtW'(WordW));

	always_comb begin
		dec.rm   = rm_value;
		dec.cin  = carry_in;
		dec.kind = kind;
		dec.op   = OP_SHIFT;
		// left shift runs as a right shift by the complement
		dec.amt  = (kind == KIND_LSL) ? (ShW'(0) - amt_raw) : amt_raw;
		if (by_register) begin
			if (rs_zero) begin
				dec.op = OP_PASS_CIN;
			end else begin
				unique case (kind)
					KIND_LSL: begin
						if (!rs_lt32) dec.op = rs_eq32 ? OP_ZERO_B0 : OP_ZERO;
					end
					KIND_LSR: begin
						if (!rs_lt32) dec.op = rs_eq32 ? OP_ZERO_B31 : OP_ZERO;
					end
					KIND_ASR: begin
						if (!rs_lt32) dec.op = OP_FILL;
					end
					KIND_ROR: begin
						// nonzero multiple of 32
						if (rs_amount[ShW-1:0] == '0) dec.op = OP_PASS_B31;
					end
					default: dec.op = OP_SHIFT;
				endcase
			end
		end else if (shift_immediate == '0) begin
			unique case (kind)
				KIND_LSL: dec.op = OP_PASS_CIN;
				KIND_LSR: dec.op = OP_ZERO_B31;
				KIND_ASR: dec.op = OP_FILL;
				KIND_ROR: dec.op = OP_RRX;
				default:  dec.op = OP_SHIFT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ctl.load) begin
			valid_s1 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && ctl.valid) begin
			dec_s1 <= dec;
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/aso_coarse_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aso_coarse_stage
// Stage 2: builds the wide shift word and shifts it by multiples of four.
// ----------------------------------------------------------------------------
module aso_coarse_stage (
	input  wire                 clk,
	input  wire                 arst_n,
	input  aso_pkg::stage_ctl_t ctl,
	input  aso_pkg::dec_t       dec_s1,
	output logic                valid_s2,
	output aso_pkg::crs_t       crs_s2
);
	import aso_pkg::*;

	logic [WideW-1:0] word;
	crs_t             crs;

	// layout is {upper, lower, guard}; the guard bit catches the last bit out
	always_comb begin
		unique case (dec_s1.kind)
			KIND_LSL: word = {dec_s1.rm, {WordW{1'b0}}, 1'b0};
			KIND_LSR: word = {{WordW{1'b0}}, dec_s1.rm, 1'b0};
			KIND_ASR: word = {{WordW{dec_s1.rm[WordW-1]}}, dec_s1.rm, 1'b0};
			KIND_ROR: word = {dec_s1.rm, dec_s1.rm, 1'b0};
			default:  word = '0;
		endcase
	end

	always_comb begin
		crs.word     = word >> {dec_s1.amt[ShW-1:2], 2'b00};
		crs.amt_fine = dec_s1.amt[1:0];
		crs.rm       = dec_s1.rm;
		crs.cin      = dec_s1.cin;
		crs.lsl      = (dec_s1.kind == KIND_LSL);
		crs.op       = dec_s1.op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ctl.load) begin
			valid_s2 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && ctl.valid) begin
			crs_s2 <= crs;
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/aso_fine_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aso_fine_stage
// Stage 3: last shift step, special-case select and the output register.
// ----------------------------------------------------------------------------
module aso_fine_stage (
	input  wire                      clk,
	input  wire                      arst_n,
	input  aso_pkg::stage_ctl_t      ctl,
	input  aso_pkg::crs_t            crs_s2,
	output logic                     valid_s3,
	output logic [aso_pkg::WordW-1:0] value_s3,
	output logic                     carry_s3
);
	import aso_pkg::*;

	logic [WideW-1:0] word;
	logic [WordW-1:0] rm;
	logic [WordW-1:0] value;
	logic             carry;

	assign word = crs_s2.word >> crs_s2.amt_fine;
	assign rm   = crs_s2.rm;

	always_comb begin
		unique case (crs_s2.op)
			OP_SHIFT: begin
				value = word[WordW:1];
				// left shift leaves its carry just above the result
				carry = crs_s2.lsl ? word[WordW+1] : word[0];
			end
			OP_PASS_CIN: begin
				value = rm;
				carry = crs_s2.cin;
			end
			OP_PASS_B31: begin
				value = rm;
				carry = rm[WordW-1];
			end
			OP_ZERO_B0: begin
				value = '0;
				carry = rm[0];
			end
			OP_ZERO_B31: begin
				value = '0;
				carry = rm[WordW-1];
			end
			OP_ZERO: begin
				value = '0;
				carry = 1'b0;
			end
			OP_FILL: begin
				value = {WordW{rm[WordW-1]}};
				carry = rm[WordW-1];
			end
			OP_RRX: begin
				value = {crs_s2.cin, rm[WordW-1:1]};
				carry = rm[0];
			end
			default: begin
				value = '0;
				carry = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ctl.load) begin
			valid_s3 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && ctl.valid) begin
			value_s3 <= value;
			carry_s3 <= carry;
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/aso_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aso_checker
// Port-level checks of the shifter operand core, bound to the top level.
// ----------------------------------------------------------------------------
`include "arm_shifter_operand_core_assert.svh"

module aso_checker (
	input wire clk,
	input wire arst_n,
	input wire req_valid,
	input wire req_ready,
	input wire rsp_valid,
	input wire rsp_ready
);
	import aso_pkg::*;

	// a response that is not taken stays offered
	`ASO_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

	// an empty or draining output means the pipe can take a request
	`ASO_ASSERT_IMP(a_req_ready, !rsp_valid || rsp_ready, req_ready)

	// with no stall a request comes out once it has passed the decode, coarse and fine stage registers
	`ASO_ASSERT_NXT(a_latency, req_valid && req_ready ##1 rsp_ready ##1 rsp_ready, rsp_valid)
endmodule

bind arm_shifter_operand_core aso_checker u_aso_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready)
);
`default_nettype wire
